@@ hw/rtl/pm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pm_pkg
// Shared types and constants of the polynomial multiplier: field widths,
// request and register codes, sequencer states and the term control word.
// ----------------------------------------------------------------------------
package pm_pkg;

    localparam int COEF_W    = 16;
    localparam int PROD_W    = 32;
    localparam int SUM_W     = 37;
    localparam int IDX_W     = 5;
    localparam int OUT_IDX_W = 6;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD_A  = 2'd0,
        REQ_LOAD_B  = 2'd1,
        REQ_COMPUTE = 2'd2
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEGREE_A = 2'd0,
        CFG_DEGREE_B = 2'd1
    } t_cfg_reg;

    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_RUN  = 1'b1
    } t_seq_state;

    typedef struct packed {
        logic                 valid;
        logic                 first;
        logic                 last_term;
        logic                 last_out;
        logic [OUT_IDX_W-1:0] k;
    } t_term_ctl;

endpackage

@@ hw/rtl/polynomial_multiply.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_multiply
// Polynomial product by discrete convolution of two stored Q8.8 coefficient
// sets, results as exact Q21.16 sums in ascending power order.
// ----------------------------------------------------------------------------
// A load transaction writes one coefficient. A compute transaction keeps
// busy high while the sequencer walks the (degree_a+1)*(degree_b+1)
// coefficient pairs and while the last pair passes the read and multiply
// stages: one multiplier does one pair per cycle, and each coefficient store
// gives one read per cycle. The last result strobes in the same cycle as busy
// falls. Results come as single-cycle strobes on o_out_valid, one per power
// of x, the last marked by o_last; the receiver must take each one in that
// cycle. Degree writes go through the configuration channel, which is always
// ready, and must only be made while busy is low.
// ----------------------------------------------------------------------------
module polynomial_multiply #(
    parameter int MAX_DEGREE = 31
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [pm_pkg::REQ_W-1:0]            i_req_type,
    input  logic [pm_pkg::IDX_W-1:0]            i_coef_index,
    input  logic signed [pm_pkg::COEF_W-1:0]    i_coef_value,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pm_pkg::IDX_W-1:0]            i_cfg_data,
    output logic                                o_out_valid,
    output logic [pm_pkg::OUT_IDX_W-1:0]        o_out_index,
    output logic signed [pm_pkg::SUM_W-1:0]     o_out_value,
    output logic                                o_last
);

    import pm_pkg::*;

    localparam int              DEPTH   = MAX_DEGREE + 1;
    localparam int              ADDR_W  = $clog2(DEPTH);
    localparam logic [IDX_W-1:0]  MAX_IDX = IDX_W'(MAX_DEGREE);
    localparam logic [ADDR_W-1:0] MAX_ADR = ADDR_W'(MAX_DEGREE);

    logic [ADDR_W-1:0] r_degree_a, r_degree_b;
    logic [ADDR_W-1:0] cfg_clamped;
    logic              accept, go, idx_ok, we_a, we_b, cfg_write;
    logic [ADDR_W-1:0] addr_a, addr_b, waddr;
    logic [COEF_W-1:0] rd_a, rd_b;
    t_term_ctl         term_ctl;
    logic              seq_busy, mac_busy;

    assign busy        = seq_busy || mac_busy;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign idx_ok      = (i_coef_index <= MAX_IDX);
    assign waddr       = i_coef_index[ADDR_W-1:0];
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign cfg_clamped = (i_cfg_data > MAX_IDX) ? MAX_ADR : i_cfg_data[ADDR_W-1:0];

    always_comb begin
        go   = 1'b0;
        we_a = 1'b0;
        we_b = 1'b0;
        unique case (i_req_type)
            REQ_LOAD_A:  we_a = accept && idx_ok;
            REQ_LOAD_B:  we_b = accept && idx_ok;
            REQ_COMPUTE: go   = accept;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree_a <= '0;
            r_degree_b <= '0;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                CFG_DEGREE_A: r_degree_a <= cfg_clamped;
                CFG_DEGREE_B: r_degree_b <= cfg_clamped;
                default: begin
                end
            endcase
        end
    end

    pm_ram #(
        .WIDTH (COEF_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (i_coef_value),
        .i_raddr (addr_a),
        .o_rdata (rd_a)
    );

    pm_ram #(
        .WIDTH (COEF_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (i_coef_value),
        .i_raddr (addr_b),
        .o_rdata (rd_b)
    );

    pm_seq #(
        .ADDR_W (ADDR_W)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (go),
        .i_degree_a (r_degree_a),
        .i_degree_b (r_degree_b),
        .o_addr_a   (addr_a),
        .o_addr_b   (addr_b),
        .o_ctl      (term_ctl),
        .o_busy     (seq_busy)
    );

    pm_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (term_ctl),
        .i_rd_a      (rd_a),
        .i_rd_b      (rd_b),
        .o_busy      (mac_busy),
        .o_out_valid (o_out_valid),
        .o_out_index (o_out_index),
        .o_out_value (o_out_value),
        .o_last      (o_last)
    );

endmodule

@@ hw/rtl/pm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pm_ram
// Generic synchronous RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/pm_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pm_seq
// Convolution sequencer: walks every product index k and, for each, every
// coefficient pair (i, k-i) inside both degrees, one pair per cycle.
// ----------------------------------------------------------------------------
module pm_seq #(
    parameter int ADDR_W = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  logic [ADDR_W-1:0]    i_degree_a,
    input  logic [ADDR_W-1:0]    i_degree_b,
    output logic [ADDR_W-1:0]    o_addr_a,
    output logic [ADDR_W-1:0]    o_addr_b,
    output pm_pkg::t_term_ctl    o_ctl,
    output logic                 o_busy
);

    import pm_pkg::*;

    t_seq_state           r_state, n_state;
    logic [OUT_IDX_W-1:0] r_k, n_k;
    logic [ADDR_W-1:0]    r_i, n_i;
    logic                 r_first, n_first;

    logic [OUT_IDX_W-1:0] deg_a6, deg_b6, i6, hi6, k_next, lo_next, diff6;
    logic                 last_term, last_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_k     <= '0;
            r_i     <= '0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_i     <= n_i;
            r_first <= n_first;
        end
    end

    always_comb begin
        deg_a6    = OUT_IDX_W'(i_degree_a);
        deg_b6    = OUT_IDX_W'(i_degree_b);
        i6        = OUT_IDX_W'(r_i);
        hi6       = (r_k < deg_a6) ? r_k : deg_a6;
        k_next    = r_k + OUT_IDX_W'(1);
        lo_next   = (k_next > deg_b6) ? (k_next - deg_b6) : '0;
        diff6     = r_k - i6;
        last_term = (i6 == hi6);
        last_out  = last_term && (r_k == (deg_a6 + deg_b6));

        n_state = r_state;
        n_k     = r_k;
        n_i     = r_i;
        n_first = r_first;

        unique case (r_state)
            SEQ_IDLE: begin
                if (i_go) begin
                    n_state = SEQ_RUN;
                    n_k     = '0;
                    n_i     = '0;
                    n_first = 1'b1;
                end
            end
            SEQ_RUN: begin
                if (last_out) begin
                    n_state = SEQ_IDLE;
                end else if (last_term) begin
                    n_k     = k_next;
                    n_i     = lo_next[ADDR_W-1:0];
                    n_first = 1'b1;
                end else begin
                    n_i     = r_i + ADDR_W'(1);
                    n_first = 1'b0;
                end
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase

        o_addr_a        = r_i;
        o_addr_b        = diff6[ADDR_W-1:0];
        o_ctl.valid     = (r_state == SEQ_RUN);
        o_ctl.first     = r_first;
        o_ctl.last_term = last_term;
        o_ctl.last_out  = last_out;
        o_ctl.k         = r_k;
        o_busy          = (r_state == SEQ_RUN);
    end

endmodule

@@ hw/rtl/pm_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pm_mac
// Multiply-accumulate datapath: aligns term control with the memory read,
// registers the Q16.16 product, accumulates the Q21.16 sum and strobes it.
// ----------------------------------------------------------------------------
module pm_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pm_pkg::t_term_ctl                   i_ctl,
    input  logic [pm_pkg::COEF_W-1:0]           i_rd_a,
    input  logic [pm_pkg::COEF_W-1:0]           i_rd_b,
    output logic                                o_busy,
    output logic                                o_out_valid,
    output logic [pm_pkg::OUT_IDX_W-1:0]        o_out_index,
    output logic signed [pm_pkg::SUM_W-1:0]     o_out_value,
    output logic                                o_last
);

    import pm_pkg::*;

    t_term_ctl                r_ctl_rd, r_ctl_mul;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [SUM_W-1:0]  r_acc, n_acc;
    logic signed [PROD_W-1:0] a_ext, b_ext;
    logic                     r_out_valid;
    logic [OUT_IDX_W-1:0]     r_out_index;
    logic                     r_out_last;

    always_comb begin
        a_ext  = PROD_W'($signed(i_rd_a));
        b_ext  = PROD_W'($signed(i_rd_b));
        n_prod = a_ext * b_ext;
        n_acc  = r_ctl_mul.first ? SUM_W'(r_prod) : (r_acc + SUM_W'(r_prod));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_rd    <= '0;
            r_ctl_mul   <= '0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_ctl_rd    <= i_ctl;
            r_ctl_mul   <= r_ctl_rd;
            r_out_valid <= r_ctl_mul.valid && r_ctl_mul.last_term;
            r_out_last  <= r_ctl_mul.valid && r_ctl_mul.last_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (r_ctl_mul.valid) begin
            r_acc       <= n_acc;
            r_out_index <= r_ctl_mul.k;
        end
    end

    assign o_busy      = r_ctl_rd.valid || r_ctl_mul.valid;
    assign o_out_valid = r_out_valid;
    assign o_out_index = r_out_index;
    assign o_out_value = r_acc;
    assign o_last      = r_out_last;

endmodule

@@ test/polynomial_multiply_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_multiply_checker
// Watches the request, degree and product channels of the polynomial
// multiplier. It keeps its own copy of both coefficient sets and of both
// degrees, expands each compute transaction into the expected product terms
// and compares every strobed term field by field, in order.
// ----------------------------------------------------------------------------
module polynomial_multiply_checker #(
    parameter int MAX_DEGREE = 31
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic [pm_pkg::REQ_W-1:0]         i_req_type,
    input  logic [pm_pkg::IDX_W-1:0]         i_coef_index,
    input  logic signed [pm_pkg::COEF_W-1:0] i_coef_value,
    input  logic                             i_cfg_valid,
    input  logic                             o_cfg_ready,
    input  logic [pm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pm_pkg::IDX_W-1:0]         i_cfg_data,
    input  logic                             o_out_valid,
    input  logic [pm_pkg::OUT_IDX_W-1:0]     o_out_index,
    input  logic signed [pm_pkg::SUM_W-1:0]  o_out_value,
    input  logic                             o_last,
    output int                               o_terms_open,
    output int                               o_fail_count
);
    import pm_pkg::*;

    typedef struct packed {
        logic [OUT_IDX_W-1:0]    pos;
        logic signed [SUM_W-1:0] coef;
        logic                    is_last;
    } t_product_term;

    logic signed [COEF_W-1:0] poly_a [0:MAX_DEGREE];
    logic signed [COEF_W-1:0] poly_b [0:MAX_DEGREE];
    int unsigned              deg_a = 0;
    int unsigned              deg_b = 0;
    int                       fail_total = 0;
    t_product_term            product_q [$];

    task automatic expand_product();
        t_product_term           term;
        logic signed [SUM_W-1:0] acc;
        int                      j;
        for (int k = 0; k <= int'(deg_a + deg_b); k++) begin
            acc = '0;
            for (int i = 0; i <= int'(deg_a); i++) begin
                j = k - i;
                if (j >= 0 && j <= int'(deg_b))
                    acc = acc + poly_a[i] * poly_b[j];
            end
            term.pos     = OUT_IDX_W'(k);
            term.coef    = acc;
            term.is_last = (k == int'(deg_a + deg_b));
            product_q.push_back(term);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_product_term want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEGREE_A: deg_a = (i_cfg_data > MAX_DEGREE) ? MAX_DEGREE : i_cfg_data;
                    CFG_DEGREE_B: deg_b = (i_cfg_data > MAX_DEGREE) ? MAX_DEGREE : i_cfg_data;
                    default: ;
                endcase
            end
            if (o_out_valid) begin
                if (product_q.size() == 0) begin
                    $error("unexpected product term: out_index %0d out_value %0d",
                           o_out_index, o_out_value);
                    fail_total++;
                end else begin
                    want = product_q.pop_front();
                    if (o_out_index !== want.pos) begin
                        $error("out_index: expected %0d, got %0d", want.pos, o_out_index);
                        fail_total++;
                    end
                    if (o_out_value !== want.coef) begin
                        $error("out_value: expected %0d, got %0d", want.coef, o_out_value);
                        fail_total++;
                    end
                    if (o_last !== want.is_last) begin
                        $error("last: expected %0b, got %0b", want.is_last, o_last);
                        fail_total++;
                    end
                end
            end
            if (start && !busy) begin
                case (i_req_type)
                    REQ_LOAD_A: begin
                        if (i_coef_index <= MAX_DEGREE)
                            poly_a[i_coef_index] = i_coef_value;
                    end
                    REQ_LOAD_B: begin
                        if (i_coef_index <= MAX_DEGREE)
                            poly_b[i_coef_index] = i_coef_value;
                    end
                    REQ_COMPUTE: expand_product();
                    default: ;
                endcase
            end
        end
        o_terms_open <= product_q.size();
        o_fail_count <= fail_total;
    end

endmodule

@@ test/polynomial_multiply_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_multiply_tb
// Drives coefficient loads, ignored requests and compute transactions into
// the polynomial multiplier over several degree settings and sender idle
// rates; the checker beside the block predicts and compares every product
// term, and this module reports the verdict.
// ----------------------------------------------------------------------------
module polynomial_multiply_tb;
    import pm_pkg::*;

    localparam int MAX_DEGREE      = 31;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int TIMEOUT_NS      = 40_000_000;

    localparam logic [REQ_W-1:0]     REQ_IGNORED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam logic [COEF_W-1:0]    Q88_MIN     = 16'h8000;
    localparam logic [COEF_W-1:0]    Q88_MAX     = 16'h7FFF;
    localparam logic [COEF_W-1:0]    Q88_ONE     = 16'h0100;

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    start        = 1'b0;
    logic                    busy;
    logic [REQ_W-1:0]        i_req_type   = '0;
    logic [IDX_W-1:0]        i_coef_index = '0;
    logic signed [COEF_W-1:0] i_coef_value = '0;
    logic                    i_cfg_valid  = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index  = '0;
    logic [IDX_W-1:0]        i_cfg_data   = '0;
    logic                    o_out_valid;
    logic [OUT_IDX_W-1:0]    o_out_index;
    logic signed [SUM_W-1:0] o_out_value;
    logic                    o_last;

    int terms_open;
    int fail_count;
    int idle_pct   = 0;
    int items_sent = 0;
    int deg_a      = 0;
    int deg_b      = 0;
    bit loaded_a [0:MAX_DEGREE];
    bit loaded_b [0:MAX_DEGREE];

    polynomial_multiply #(
        .MAX_DEGREE(MAX_DEGREE)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .o_out_index  (o_out_index),
        .o_out_value  (o_out_value),
        .o_last       (o_last)
    );

    polynomial_multiply_checker #(
        .MAX_DEGREE(MAX_DEGREE)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .o_out_index  (o_out_index),
        .o_out_value  (o_out_value),
        .o_last       (o_last),
        .o_terms_open (terms_open),
        .o_fail_count (fail_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [COEF_W-1:0] rand_q88();
        case ($urandom_range(9))
            0:       return Q88_MIN;
            1:       return Q88_MAX;
            2:       return '0;
            3:       return '1;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    task automatic issue(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
                         input logic [COEF_W-1:0] val);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_req_type   <= req;
        i_coef_index <= idx;
        i_coef_value <= val;
        do @(posedge i_clk); while (busy);
        if (req == REQ_LOAD_A)
            loaded_a[idx] = 1'b1;
        if (req == REQ_LOAD_B)
            loaded_b[idx] = 1'b1;
        if (req != REQ_IGNORED)
            items_sent++;
    endtask

    // hold off until every product term is out and the block is idle
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (terms_open != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IDX_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_degrees(input int da, input int db);
        write_reg(CFG_DEGREE_A, IDX_W'(da));
        write_reg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, IDX_W'($urandom));
        write_reg(CFG_DEGREE_B, IDX_W'(db));
        deg_a = da;
        deg_b = db;
    endtask

    // every coefficient the product reads gets loaded first
    task automatic run_product();
        for (int i = 0; i <= deg_a; i++)
            if (!loaded_a[i])
                issue(REQ_LOAD_A, IDX_W'(i), rand_q88());
        for (int i = 0; i <= deg_b; i++)
            if (!loaded_b[i])
                issue(REQ_LOAD_B, IDX_W'(i), rand_q88());
        issue(REQ_COMPUTE, IDX_W'($urandom), COEF_W'($urandom));
        if ($urandom_range(19) == 0)
            drain();
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 12) begin
            run_product();
        end else if (pick < 72) begin
            if ($urandom_range(1))
                issue(REQ_LOAD_A, IDX_W'($urandom_range(deg_a)), rand_q88());
            else
                issue(REQ_LOAD_B, IDX_W'($urandom_range(deg_b)), rand_q88());
        end else if (pick < 92) begin
            issue($urandom_range(1) ? REQ_LOAD_A : REQ_LOAD_B, IDX_W'($urandom), rand_q88());
        end else begin
            issue(REQ_IGNORED, IDX_W'($urandom), COEF_W'($urandom));
        end
    endtask

    initial begin
        int da;
        int db;
        int phase_end;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // degrees are zero out of reset
        issue(REQ_LOAD_A, '0, Q88_MIN);
        issue(REQ_LOAD_B, '0, Q88_MIN);
        issue(REQ_COMPUTE, '1, '1);
        drain();
        issue(REQ_LOAD_B, '0, Q88_MAX);
        issue(REQ_COMPUTE, '0, '0);
        issue(REQ_LOAD_A, '1, Q88_MAX);
        issue(REQ_LOAD_B, '1, Q88_MIN);
        issue(REQ_IGNORED, '1, '1);
        issue(REQ_IGNORED, '0, Q88_MIN);
        issue(REQ_LOAD_A, '0, '1);
        issue(REQ_LOAD_B, '0, '0);
        issue(REQ_COMPUTE, '1, '0);
        issue(REQ_LOAD_A, '0, Q88_ONE);
        issue(REQ_LOAD_B, '0, '1);
        issue(REQ_COMPUTE, '0, '1);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0:       begin da = MAX_DEGREE; db = MAX_DEGREE; end
                1:       begin da = MAX_DEGREE; db = 0;          end
                2:       begin da = 0;          db = MAX_DEGREE; end
                3:       begin da = 0;          db = 0;          end
                default: begin da = $urandom_range(6); db = $urandom_range(6); end
            endcase
            set_degrees(da, db);
            case (p % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 46;
                default: idle_pct = 34;
            endcase
            if (p == 0) begin
                // largest positive and most negative middle coefficient
                for (int i = 0; i <= MAX_DEGREE; i++) begin
                    issue(REQ_LOAD_A, IDX_W'(i), Q88_MIN);
                    issue(REQ_LOAD_B, IDX_W'(i), Q88_MIN);
                end
                issue(REQ_COMPUTE, '0, '0);
                for (int i = 0; i <= MAX_DEGREE; i++)
                    issue(REQ_LOAD_B, IDX_W'(i), Q88_MAX);
                issue(REQ_COMPUTE, '1, '1);
            end
            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end)
                random_item();
        end

        drain();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
